/* hdl/plpu_pkg.sv */
// Shared types and constants of the 3D patch upsampler.
`default_nettype none
package plpu_pkg;

    // Field widths fixed by the stream format.
    localparam int RES_W      = 38;
    localparam int COORD_W    = 8;
    localparam int SIZE_W     = 7;
    localparam int IDX_W      = 10;
    localparam int ROW_W      = 5;
    localparam int TAPS       = 27;
    localparam int TABLE_SIZE = 729;
    localparam int CFG_IDX_W  = 2;
    localparam int MIN_SIZE   = 3;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_X       = 64;
    localparam int DEF_MAX_Y       = 64;
    localparam int DEF_MAX_Z       = 64;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_WEIGHT_BITS = 16;

    // Division of a table slot by 27: (idx * 607) >> 14 is exact for idx below 729.
    localparam int DIV27_MUL   = 607;
    localparam int DIV27_SHIFT = 14;

    // Request kinds carried in tuser.
    localparam logic REQ_WEIGHT = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_X = 2'd0,
        CFG_SIZE_Y = 2'd1,
        CFG_SIZE_Z = 2'd2
    } cfg_reg_t;

    // One result row travelling down the cell chain.
    typedef struct packed {
        logic               valid;
        logic [ROW_W-1:0]   row;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               last;
    } tok_t;

    // Control part of a window sample travelling on the load lane.
    typedef struct packed {
        logic             valid;
        logic [ROW_W-1:0] idx;
    } lane_t;

endpackage
`default_nettype wire

/* hdl/plpu_cell.sv */
// One cell of the dot-product chain: a weight column, a window sample and an accumulate stage.
`default_nettype none
module plpu_cell #(
    parameter int CELL_IDX    = 0,
    parameter int SAMPLE_BITS = plpu_pkg::DEF_SAMPLE_BITS,
    parameter int WEIGHT_BITS = plpu_pkg::DEF_WEIGHT_BITS
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   adv,
    input  plpu_pkg::tok_t                        tok_in,
    input  wire signed [plpu_pkg::RES_W-1:0]      sum_in,
    input  plpu_pkg::lane_t                       lane_in,
    input  wire signed [SAMPLE_BITS-1:0]          lane_smp_in,
    input  wire                                   wr_valid,
    input  wire        [plpu_pkg::ROW_W-1:0]      wr_row,
    input  wire        [plpu_pkg::ROW_W-1:0]      wr_col,
    input  wire signed [WEIGHT_BITS-1:0]          wr_value,
    output plpu_pkg::tok_t                        tok_out,
    output logic signed [plpu_pkg::RES_W-1:0]     sum_out,
    output plpu_pkg::lane_t                       lane_out,
    output logic signed [SAMPLE_BITS-1:0]         lane_smp_out
);

    localparam int PROD_W = SAMPLE_BITS + WEIGHT_BITS;
    localparam int BANK_D = 1 << plpu_pkg::ROW_W;

    logic signed [WEIGHT_BITS-1:0]     bank_reg [BANK_D];
    logic signed [SAMPLE_BITS-1:0]     win_reg;
    logic signed [SAMPLE_BITS-1:0]     win_use;
    logic                              hit;
    plpu_pkg::tok_t                    tok_a_reg;
    plpu_pkg::tok_t                    tok_b_reg;
    logic signed [plpu_pkg::RES_W-1:0] sum_a_reg;
    logic signed [plpu_pkg::RES_W-1:0] sum_b_reg;
    logic signed [PROD_W-1:0]          prod_a_reg;
    plpu_pkg::lane_t                   lane_reg;
    logic signed [SAMPLE_BITS-1:0]     lane_smp_reg;

    // Weight column of this cell, one entry per result row.
    always_ff @(posedge aclk) begin
        if (wr_valid && wr_col == plpu_pkg::ROW_W'(CELL_IDX)) begin
            bank_reg[wr_row] <= wr_value;
        end
    end

    // The window sample for this cell is taken off the lane as the first row arrives.
    assign hit     = lane_in.valid && lane_in.idx == plpu_pkg::ROW_W'(CELL_IDX);
    assign win_use = hit ? lane_smp_in : win_reg;

    // Payload registers: sample, product and partial sums.
    always_ff @(posedge aclk) begin
        if (adv) begin
            win_reg      <= win_use;
            prod_a_reg   <= PROD_W'(win_use) * PROD_W'(bank_reg[tok_in.row]);
            sum_a_reg    <= sum_in;
            sum_b_reg    <= sum_a_reg + plpu_pkg::RES_W'(prod_a_reg);
            lane_smp_reg <= lane_smp_in;
        end
    end

    // Control registers: row tokens and lane tags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_a_reg <= '0;
            tok_b_reg <= '0;
            lane_reg  <= '0;
        end else if (adv) begin
            tok_a_reg <= tok_in;
            tok_b_reg <= tok_a_reg;
            lane_reg  <= lane_in;
        end
    end

    assign tok_out      = tok_b_reg;
    assign sum_out      = sum_b_reg;
    assign lane_out     = lane_reg;
    assign lane_smp_out = lane_smp_reg;

endmodule
`default_nettype wire

/* hdl/plpu_front.sv */
// Sample history ring, raster position tracking and the window fetch sequencer.
`default_nettype none
module plpu_front #(
    parameter int MAX_X       = plpu_pkg::DEF_MAX_X,
    parameter int MAX_Y       = plpu_pkg::DEF_MAX_Y,
    parameter int MAX_Z       = plpu_pkg::DEF_MAX_Z,
    parameter int SAMPLE_BITS = plpu_pkg::DEF_SAMPLE_BITS
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 adv,
    input  wire                                 smp_we,
    input  wire signed [SAMPLE_BITS-1:0]        smp_data,
    input  wire                                 cfg_restart,
    input  wire [plpu_pkg::SIZE_W-1:0]          size_x,
    input  wire [plpu_pkg::SIZE_W-1:0]          size_y,
    input  wire [plpu_pkg::SIZE_W-1:0]          size_z,
    input  wire [2*plpu_pkg::SIZE_W-1:0]        plane,
    output logic                                busy,
    output logic                                issue,
    output plpu_pkg::tok_t                      tok,
    output plpu_pkg::lane_t                     lane,
    output logic signed [SAMPLE_BITS-1:0]       lane_smp
);

    localparam int HIST_DEPTH = 2 * MAX_Y * MAX_Z + 2 * MAX_Z + 3;
    localparam int AW  = $clog2(HIST_DEPTH);
    localparam int CW  = AW + 2;
    localparam int PXW = $clog2(MAX_X);
    localparam int PYW = $clog2(MAX_Y);
    localparam int PZW = $clog2(MAX_Z);
    localparam int SW  = plpu_pkg::SIZE_W + 2;
    localparam int CRW = plpu_pkg::COORD_W;

    logic signed [SAMPLE_BITS-1:0] hist_mem [HIST_DEPTH];
    logic signed [SAMPLE_BITS-1:0] rdata_reg;
    logic [AW-1:0]  wp_reg, wp_next;
    logic [AW-1:0]  raddr_reg, raddr_next;
    logic [PXW-1:0] pos_x_reg, pos_x_next;
    logic [PYW-1:0] pos_y_reg, pos_y_next;
    logic [PZW-1:0] pos_z_reg, pos_z_next;
    logic           active_reg, active_next;
    logic [1:0]     a_reg, b_reg, c_reg, a_next, b_next, c_next;
    logic [plpu_pkg::ROW_W-1:0] k_reg, k_next;
    logic [CRW-1:0] cx3_reg, cy3_reg, cz3_reg;
    plpu_pkg::tok_t tok_reg, tok_next;
    logic           complete;
    logic [CW-1:0]  offset0, start_raw, start_addr, inc, step_raw;

    // History ring: one write per accepted sample, one registered read per fetch step.
    always_ff @(posedge aclk) begin
        if (smp_we) begin
            hist_mem[wp_reg] <= smp_data;
        end
        if (adv) begin
            rdata_reg <= hist_mem[raddr_reg];
        end
    end

    assign complete = (pos_x_reg >= PXW'(2)) && (pos_y_reg >= PYW'(2)) && (pos_z_reg >= PZW'(2));
    assign wp_next  = (wp_reg == AW'(HIST_DEPTH - 1)) ? '0 : wp_reg + 1'b1;

    // Oldest window sample sits 2*plane + 2*size_z + 2 entries behind the newest.
    assign offset0    = (CW'(plane) << 1) + (CW'(size_z) << 1) + CW'(2);
    assign start_raw  = CW'(wp_reg) + CW'(HIST_DEPTH) - offset0;
    assign start_addr = (start_raw >= CW'(HIST_DEPTH)) ? start_raw - CW'(HIST_DEPTH) : start_raw;

    // Address step to the next window sample in a, b, c order.
    always_comb begin
        if (c_reg != 2'd2) begin
            inc = CW'(1);
        end else if (b_reg != 2'd2) begin
            inc = CW'(size_z) - CW'(2);
        end else begin
            inc = CW'(plane) - (CW'(size_z) << 1) - CW'(2);
        end
    end
    assign step_raw   = CW'(raddr_reg) + inc;
    assign raddr_next = (step_raw >= CW'(HIST_DEPTH)) ? AW'(step_raw - CW'(HIST_DEPTH))
                                                      : AW'(step_raw);

    // Raster position after each accepted sample; a size register write restarts it at zero.
    always_comb begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        pos_z_next = pos_z_reg;
        if (cfg_restart) begin
            pos_x_next = '0;
            pos_y_next = '0;
            pos_z_next = '0;
        end else if (smp_we) begin
            if (SW'(pos_z_reg) + SW'(1) >= SW'(size_z)) begin
                pos_z_next = '0;
                if (SW'(pos_y_reg) + SW'(1) >= SW'(size_y)) begin
                    pos_y_next = '0;
                    if (SW'(pos_x_reg) + SW'(1) >= SW'(size_x)) begin
                        pos_x_next = '0;
                    end else begin
                        pos_x_next = pos_x_reg + 1'b1;
                    end
                end else begin
                    pos_y_next = pos_y_reg + 1'b1;
                end
            end else begin
                pos_z_next = pos_z_reg + 1'b1;
            end
        end
    end

    // Fetch sequencer: 27 steps per window, one history read and one row token each.
    assign issue = active_reg && adv;
    always_comb begin
        active_next = active_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        k_next      = k_reg;
        tok_next    = tok_reg;
        if (adv) begin
            tok_next.valid = active_reg;
            tok_next.row   = k_reg;
            tok_next.x     = cx3_reg + CRW'(a_reg);
            tok_next.y     = cy3_reg + CRW'(b_reg);
            tok_next.z     = cz3_reg + CRW'(c_reg);
            tok_next.last  = (k_reg == plpu_pkg::ROW_W'(plpu_pkg::TAPS - 1));
        end
        if (issue) begin
            k_next = k_reg + 1'b1;
            if (c_reg == 2'd2) begin
                c_next = '0;
                if (b_reg == 2'd2) begin
                    b_next = '0;
                    a_next = a_reg + 1'b1;
                end else begin
                    b_next = b_reg + 1'b1;
                end
            end else begin
                c_next = c_reg + 1'b1;
            end
            if (k_reg == plpu_pkg::ROW_W'(plpu_pkg::TAPS - 1)) begin
                active_next = 1'b0;
            end
        end
        if (smp_we && complete) begin
            active_next = 1'b1;
            a_next      = '0;
            b_next      = '0;
            c_next      = '0;
            k_next      = '0;
        end
    end

    // Sequencer address and output coordinate bases.
    always_ff @(posedge aclk) begin
        if (smp_we && complete) begin
            raddr_reg <= AW'(start_addr);
            cx3_reg   <= CRW'((CW'(pos_x_reg) - CW'(2)) * CW'(3));
            cy3_reg   <= CRW'((CW'(pos_y_reg) - CW'(2)) * CW'(3));
            cz3_reg   <= CRW'((CW'(pos_z_reg) - CW'(2)) * CW'(3));
        end else if (issue) begin
            raddr_reg <= raddr_next;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg     <= '0;
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            pos_z_reg  <= '0;
            active_reg <= 1'b0;
            a_reg      <= '0;
            b_reg      <= '0;
            c_reg      <= '0;
            k_reg      <= '0;
            tok_reg    <= '0;
        end else begin
            if (smp_we) begin
                wp_reg <= wp_next;
            end
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
            pos_z_reg  <= pos_z_next;
            active_reg <= active_next;
            a_reg      <= a_next;
            b_reg      <= b_next;
            c_reg      <= c_next;
            k_reg      <= k_next;
            tok_reg    <= tok_next;
        end
    end

    // The sequencer is free again in the cycle that issues the last step of a window.
    assign busy       = active_reg
                        && !(adv && k_reg == plpu_pkg::ROW_W'(plpu_pkg::TAPS - 1));

    // Token and lane sample leave together: sample k enters the lane with row token k.
    assign tok        = tok_reg;
    assign lane.valid = tok_reg.valid;
    assign lane.idx   = tok_reg.row;
    assign lane_smp   = rdata_reg;

endmodule
`default_nettype wire

/* hdl/patch_linear_upsample_3d.sv */
// Top level: configuration, weight routing, the 27-cell dot-product chain and the output register.
// A window-completing sample's results pass the sequencer, the cell chain and the output register,
// then leave one a cycle while the output is not stalled. Such a sample holds the input while its
// window is fetched through the single history read port feeding the cell lane; other samples do not.
// A weight load waits until every issued result has been transferred and no window is being fetched.
// Reset (aresetn low, synchronous) clears positions and all valid bits, sets sizes to 64 clamped
// to each axis maximum; weight and history stores hold unknown data until written.
`default_nettype none
module patch_linear_upsample_3d #(
    parameter int MAX_X       = plpu_pkg::DEF_MAX_X,
    parameter int MAX_Y       = plpu_pkg::DEF_MAX_Y,
    parameter int MAX_Z       = plpu_pkg::DEF_MAX_Z,
    parameter int SAMPLE_BITS = plpu_pkg::DEF_SAMPLE_BITS,
    parameter int WEIGHT_BITS = plpu_pkg::DEF_WEIGHT_BITS,
    localparam int IN_RAW     = plpu_pkg::IDX_W + WEIGHT_BITS + SAMPLE_BITS,
    localparam int IN_W       = ((IN_RAW + 7) / 8) * 8,
    localparam int OUT_RAW    = plpu_pkg::RES_W + 3 * plpu_pkg::COORD_W,
    localparam int OUT_W      = ((OUT_RAW + 7) / 8) * 8
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // weight_index, weight_value, sample, zero fill
    input  wire [IN_W-1:0]                   s_tdata,
    // req_type
    input  wire                              s_tuser,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // result_value, out_x, out_y, out_z, zero fill
    output logic [OUT_W-1:0]                 m_tdata,
    output logic                             m_tlast,
    input  wire                              cfg_we,
    input  wire [plpu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [plpu_pkg::SIZE_W-1:0]       cfg_data
);

    localparam int TAPS  = plpu_pkg::TAPS;
    localparam int RES_W = plpu_pkg::RES_W;
    localparam int RW    = plpu_pkg::ROW_W;
    localparam int SZW   = plpu_pkg::SIZE_W;
    localparam int DIVW  = plpu_pkg::IDX_W + 10;
    localparam int CNTW  = 8;

    logic [SZW-1:0]   size_x_reg, size_y_reg, size_z_reg, cfg_clamped;
    logic [2*SZW-1:0] plane_reg;
    logic             s_xfer, m_xfer, adv, busy, issue, smp_we, cfg_restart;
    logic [plpu_pkg::IDX_W-1:0]      w_idx;
    logic signed [WEIGHT_BITS-1:0]   w_val;
    logic signed [SAMPLE_BITS-1:0]   smp_val;
    logic [RW-1:0]                   w_row, w_col;
    logic                            wr_valid_reg;
    logic [RW-1:0]                   wr_row_reg, wr_col_reg;
    logic signed [WEIGHT_BITS-1:0]   wr_value_reg;
    logic [CNTW-1:0]                 inflight_reg, inflight_next;
    logic                            m_valid_reg, m_last_reg;
    logic [OUT_W-1:0]                m_data_reg;

    plpu_pkg::tok_t                  tok_c   [TAPS+1];
    logic signed [RES_W-1:0]         sum_c   [TAPS+1];
    plpu_pkg::lane_t                 lane_c  [TAPS+1];
    logic signed [SAMPLE_BITS-1:0]   lsmp_c  [TAPS+1];

    assign w_idx   = s_tdata[plpu_pkg::IDX_W-1:0];
    assign w_val   = s_tdata[plpu_pkg::IDX_W +: WEIGHT_BITS];
    assign smp_val = s_tdata[plpu_pkg::IDX_W + WEIGHT_BITS +: SAMPLE_BITS];

    // Samples flow while no window is being fetched; weights also wait for a drained chain.
    assign s_tready = !busy && (s_tuser == plpu_pkg::REQ_SAMPLE || inflight_reg == '0);
    assign s_xfer   = s_tvalid && s_tready;
    assign smp_we   = s_xfer && s_tuser == plpu_pkg::REQ_SAMPLE;
    assign m_xfer   = m_valid_reg && m_tready;
    assign adv      = !m_valid_reg || m_tready;

    // Size register writes, saturated into the legal range of each axis.
    function automatic logic [SZW-1:0] clamp_size(input logic [SZW-1:0] v, input int maxv);
        logic [SZW+2:0] vx;
        vx = (SZW + 3)'(v);
        if (vx < (SZW + 3)'(plpu_pkg::MIN_SIZE)) begin
            return SZW'(plpu_pkg::MIN_SIZE);
        end else if (vx > (SZW + 3)'(maxv)) begin
            return SZW'(maxv);
        end
        return v;
    endfunction

    always_comb begin
        unique case (plpu_pkg::cfg_reg_t'(cfg_index))
            plpu_pkg::CFG_SIZE_X: cfg_clamped = clamp_size(cfg_data, MAX_X);
            plpu_pkg::CFG_SIZE_Y: cfg_clamped = clamp_size(cfg_data, MAX_Y);
            plpu_pkg::CFG_SIZE_Z: cfg_clamped = clamp_size(cfg_data, MAX_Z);
            default:              cfg_clamped = cfg_data;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= clamp_size(SZW'(64), MAX_X);
            size_y_reg <= clamp_size(SZW'(64), MAX_Y);
            size_z_reg <= clamp_size(SZW'(64), MAX_Z);
        end else if (cfg_we) begin
            unique case (plpu_pkg::cfg_reg_t'(cfg_index))
                plpu_pkg::CFG_SIZE_X: size_x_reg <= cfg_clamped;
                plpu_pkg::CFG_SIZE_Y: size_y_reg <= cfg_clamped;
                plpu_pkg::CFG_SIZE_Z: size_z_reg <= cfg_clamped;
                default: ;
            endcase
        end
    end

    // Any size register write restarts the volume.
    assign cfg_restart = cfg_we && (cfg_index == plpu_pkg::CFG_SIZE_X
                                    || cfg_index == plpu_pkg::CFG_SIZE_Y
                                    || cfg_index == plpu_pkg::CFG_SIZE_Z);

    // Plane size is registered from the size registers and follows them in the next cycle.
    always_ff @(posedge aclk) begin
        plane_reg <= (2 * SZW)'(size_y_reg) * (2 * SZW)'(size_z_reg);
    end

    // Split a weight slot into result row and window column.
    assign w_row = RW'(((DIVW)'(w_idx) * DIVW'(plpu_pkg::DIV27_MUL)) >> plpu_pkg::DIV27_SHIFT);
    assign w_col = RW'(w_idx - plpu_pkg::IDX_W'(w_row) * plpu_pkg::IDX_W'(TAPS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_valid_reg <= 1'b0;
        end else begin
            wr_valid_reg <= s_xfer && s_tuser == plpu_pkg::REQ_WEIGHT
                            && w_idx < plpu_pkg::IDX_W'(plpu_pkg::TABLE_SIZE);
        end
    end
    always_ff @(posedge aclk) begin
        wr_row_reg   <= w_row;
        wr_col_reg   <= w_col;
        wr_value_reg <= w_val;
    end

    // Count of row tokens issued but not yet transferred out.
    always_comb begin
        inflight_next = inflight_reg;
        if (issue && !m_xfer) begin
            inflight_next = inflight_reg + 1'b1;
        end else if (!issue && m_xfer) begin
            inflight_next = inflight_reg - 1'b1;
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    plpu_front #(
        .MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z), .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .smp_we(smp_we), .smp_data(smp_val), .cfg_restart(cfg_restart),
        .size_x(size_x_reg), .size_y(size_y_reg), .size_z(size_z_reg), .plane(plane_reg),
        .busy(busy), .issue(issue),
        .tok(tok_c[0]), .lane(lane_c[0]), .lane_smp(lsmp_c[0])
    );

    assign sum_c[0] = '0;

    // The chain: each cell adds its column product and hands the row on.
    for (genvar g = 0; g < TAPS; g++) begin : g_cell
        plpu_cell #(
            .CELL_IDX(g), .SAMPLE_BITS(SAMPLE_BITS), .WEIGHT_BITS(WEIGHT_BITS)
        ) u_cell (
            .aclk(aclk), .aresetn(aresetn), .adv(adv),
            .tok_in(tok_c[g]), .sum_in(sum_c[g]),
            .lane_in(lane_c[g]), .lane_smp_in(lsmp_c[g]),
            .wr_valid(wr_valid_reg), .wr_row(wr_row_reg), .wr_col(wr_col_reg),
            .wr_value(wr_value_reg),
            .tok_out(tok_c[g+1]), .sum_out(sum_c[g+1]),
            .lane_out(lane_c[g+1]), .lane_smp_out(lsmp_c[g+1])
        );
    end

    // Output register; the whole chain advances only when it can take a new result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= tok_c[TAPS].valid;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= OUT_W'({tok_c[TAPS].z, tok_c[TAPS].y, tok_c[TAPS].x, sum_c[TAPS]});
            m_last_reg <= tok_c[TAPS].last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule
`default_nettype wire

/* hdl/plpu_checker.sv */
// Port-level assertions for the upsampler, bound to the top level.
`default_nettype none
module plpu_checker #(
    parameter int IN_W  = 48,
    parameter int OUT_W = 64
) (
    input wire             aclk,
    input wire             aresetn,
    input wire             s_tvalid,
    input wire             s_tready,
    input wire             s_tuser,
    input wire             m_tvalid,
    input wire             m_tready,
    input wire [OUT_W-1:0] m_tdata,
    input wire             m_tlast
);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // A weight transfer only happens once every result has left.
    a_weight_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == plpu_pkg::REQ_WEIGHT |-> !m_tvalid)
        else $error("weight accepted with results outstanding");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid after reset");

    // After a weight transfer no result can appear in the next cycle.
    a_weight_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == plpu_pkg::REQ_WEIGHT |=> !m_tvalid)
        else $error("result right after weight load");

endmodule

bind patch_linear_upsample_3d plpu_checker #(.IN_W(IN_W), .OUT_W(OUT_W)) u_plpu_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast)
);
`default_nettype wire
